// ----- rtl/core/sha1_pkg.sv -----
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared constants, types and round helpers for the SHA-1 hash engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam logic [4:0][31:0] IV_WORDS = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };
  localparam logic [3:0][31:0] K_WORDS = {
    32'hca62c1d6, 32'h8f1bbcdc, 32'h6ed9eba1, 32'h5a827999
  };

  localparam logic [6:0] LAST_ROUND  = 7'd79;
  localparam logic [6:0] ROUND_SEL1  = 7'd20;
  localparam logic [6:0] ROUND_SEL2  = 7'd40;
  localparam logic [6:0] ROUND_SEL3  = 7'd60;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [3:0] LEN_HI_ADDR = 4'd14;
  localparam logic [3:0] LEN_LO_ADDR = 4'd15;
  localparam logic [2:0] WORD_BYTES  = 3'd4;
  localparam logic [2:0] LAST_IDX    = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_DATA, S_MARK, S_PAD, S_LENH, S_LENL, S_COMP, S_OUT
  } ctl_state_t;

  typedef enum logic [1:0] {
    R_IDLE, R_ROUND, R_ADD
  } rnd_state_t;

  typedef struct packed {
    logic        wr_en;
    logic [3:0]  addr;
    logic [3:0]  be;
    logic [31:0] data;
  } sched_ctl_t;

  typedef struct packed {
    logic start;
    logic reinit;
  } rnd_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rnd_sts_t;

  function automatic logic [31:0] round_f(input logic [1:0] sel, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    unique case (sel)
      2'd0:    f = d ^ (b & (c ^ d));
      2'd2:    f = (b & c) | (d & (b | c));
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

// ----- rtl/core/sha1_if.sv -----
// ----------------------------------------------------------------------------
// sha1 channel interfaces
// Valid/ready channels for message words in and digest words out.
// ----------------------------------------------------------------------------
interface sha1_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_in;

  modport source (output valid, output data_word, output byte_count, output last_in,
                  input ready);
  modport sink (input valid, input data_word, input byte_count, input last_in,
                output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_out;

  modport source (output valid, output digest_word, output word_index, output last_out,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_out,
                output ready);
endinterface

// ----- rtl/core/sha1_hash_engine.sv -----
// ----------------------------------------------------------------------------
// sha1_hash_engine
// SHA-1 engine: packs message words into 64-byte blocks, compresses each
// block, pads the message and returns the digest as five words.
// ----------------------------------------------------------------------------
// an aligned four-byte word is written whole, a partial or unaligned word byte by byte
// each full block is compressed: 80 rounds in the shared round unit, then 1 update
// last word: data bytes, then 0x80, then zero bytes or aligned zero words,
// then the two length words, a compression per final block, then 5 digest words, one per handshake
// a new input word is taken only once the last is written and any block it filled is compressed
// reset: idle, chaining words to initial values, fill and length zero
module sha1_hash_engine (
  input logic       clk,
  input logic       rst_n,
  sha1_in_if.sink   in_ch,
  sha1_out_if.source out_ch
);
  import sha1_pkg::*;

  ctl_state_t       state_r, state_nxt;
  ctl_state_t       resume_r, resume_nxt;
  logic [31:0]      data_r, data_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic             last_r, last_nxt;
  logic [5:0]       fill_r, fill_nxt;
  logic [63:0]      len_r, len_nxt;
  logic [2:0]       oidx_r, oidx_nxt;

  sched_ctl_t       sctl;
  rnd_ctl_t         rctl;
  rnd_sts_t         rsts;
  logic [31:0]      w_word;
  logic [4:0][31:0] chain;

  logic [2:0]       n_in;
  logic             do_wr;
  logic             is_word;
  logic [7:0]       wr_byte;
  logic [31:0]      wr_word;
  logic [6:0]       fill_sum;
  logic [2:0]       idx_step;
  ctl_state_t       follow;

  sha1_sched u_sched (
    .clk   (clk),
    .ctl   (sctl),
    .shift (rsts.busy),
    .w_out (w_word)
  );

  sha1_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rctl),
    .w_in  (w_word),
    .sts   (rsts),
    .chain (chain)
  );

  always_comb begin
    n_in = (in_ch.byte_count > WORD_BYTES) ? WORD_BYTES : in_ch.byte_count;
    unique case (idx_r[1:0])
      2'd0:    wr_byte = data_r[31:24];
      2'd1:    wr_byte = data_r[23:16];
      2'd2:    wr_byte = data_r[15:8];
      default: wr_byte = data_r[7:0];
    endcase
    wr_word  = data_r;
    is_word  = 1'b0;
    do_wr    = 1'b0;
    follow   = state_r;
    idx_step = is_word ? WORD_BYTES : 3'd1;

    state_nxt  = state_r;
    resume_nxt = resume_r;
    data_nxt   = data_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    last_nxt   = last_r;
    fill_nxt   = fill_r;
    len_nxt    = len_r;
    oidx_nxt   = oidx_r;
    sctl       = '0;
    rctl       = '0;

    in_ch.ready  = (state_r == S_IDLE);
    out_ch.valid = (state_r == S_OUT);

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          data_nxt = in_ch.data_word;
          cnt_nxt  = n_in;
          last_nxt = in_ch.last_in;
          idx_nxt  = '0;
          len_nxt  = len_r + {58'd0, n_in, 3'd0};
          if (n_in != 3'd0) begin
            state_nxt = S_DATA;
          end else if (in_ch.last_in) begin
            state_nxt = S_MARK;
          end
        end
      end
      S_DATA: begin
        do_wr    = 1'b1;
        is_word  = (fill_r[1:0] == 2'd0) && (cnt_r == WORD_BYTES) && (idx_r == 3'd0);
        idx_step = is_word ? WORD_BYTES : 3'd1;
        idx_nxt  = idx_r + idx_step;
        if (idx_nxt != cnt_r) begin
          follow = S_DATA;
        end else if (last_r) begin
          follow = S_MARK;
        end else begin
          follow = S_IDLE;
        end
      end
      S_MARK: begin
        do_wr   = 1'b1;
        wr_byte = PAD_BYTE;
        follow  = S_PAD;
      end
      S_PAD: begin
        if (fill_r == LEN_POS) begin
          state_nxt = S_LENH;
        end else begin
          do_wr   = 1'b1;
          is_word = (fill_r[1:0] == 2'd0);
          wr_byte = '0;
          wr_word = '0;
          follow  = S_PAD;
        end
      end
      S_LENH: begin
        sctl.wr_en = 1'b1;
        sctl.addr  = LEN_HI_ADDR;
        sctl.be    = 4'hf;
        sctl.data  = len_r[63:32];
        state_nxt  = S_LENL;
      end
      S_LENL: begin
        sctl.wr_en = 1'b1;
        sctl.addr  = LEN_LO_ADDR;
        sctl.be    = 4'hf;
        sctl.data  = len_r[31:0];
        rctl.start = 1'b1;
        fill_nxt   = '0;
        resume_nxt = S_OUT;
        oidx_nxt   = '0;
        state_nxt  = S_COMP;
      end
      S_COMP: begin
        if (rsts.done) begin
          state_nxt = resume_r;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == LAST_IDX) begin
            oidx_nxt    = '0;
            rctl.reinit = 1'b1;
            fill_nxt    = '0;
            len_nxt     = '0;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    fill_sum = {1'b0, fill_r} + (is_word ? 7'd4 : 7'd1);
    if (do_wr) begin
      sctl.wr_en = 1'b1;
      sctl.addr  = fill_r[5:2];
      sctl.be    = is_word ? 4'hf : (4'b1000 >> fill_r[1:0]);
      sctl.data  = is_word ? wr_word : {4{wr_byte}};
      fill_nxt   = fill_sum[5:0];
      if (fill_sum[6]) begin
        rctl.start = 1'b1;
        resume_nxt = follow;
        state_nxt  = S_COMP;
      end else begin
        state_nxt = follow;
      end
    end

    out_ch.digest_word = chain[oidx_r];
    out_ch.word_index  = oidx_r;
    out_ch.last_out    = (oidx_r == LAST_IDX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      resume_r <= S_IDLE;
      fill_r   <= '0;
      len_r    <= '0;
      oidx_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      resume_r <= resume_nxt;
      fill_r   <= fill_nxt;
      len_r    <= len_nxt;
      oidx_r   <= oidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    last_r <= last_nxt;
  end

  a_no_out_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !out_ch.valid)
    else $error("digest word shown right after an input word");

  a_ready_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last_out |=> in_ch.ready)
    else $error("engine not ready after final digest word");

  a_done_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    rsts.done |-> state_r == S_COMP)
    else $error("compression finished outside wait state");

  a_len_at_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LENH |-> fill_r == LEN_POS)
    else $error("length written at wrong fill position");

endmodule

// ----- rtl/core/sha1_sched.sv -----
// ----------------------------------------------------------------------------
// sha1_sched
// Block buffer with byte-lane writes that doubles as the message schedule
// shift line during compression.
// ----------------------------------------------------------------------------
module sha1_sched (
  input  logic                 clk,
  input  sha1_pkg::sched_ctl_t ctl,
  input  logic                 shift,
  output logic [31:0]          w_out
);
  import sha1_pkg::*;

  logic [31:0] blk_r [16];
  logic [31:0] mix;
  logic [31:0] w_nxt;

  always_comb begin
    mix   = blk_r[13] ^ blk_r[8] ^ blk_r[2] ^ blk_r[0];
    w_nxt = {mix[30:0], mix[31]};
    w_out = blk_r[0];
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      for (int i = 0; i < 15; i++) begin
        blk_r[i] <= blk_r[i+1];
      end
      blk_r[15] <= w_nxt;
    end else if (ctl.wr_en) begin
      for (int l = 0; l < 4; l++) begin
        if (ctl.be[l]) begin
          blk_r[ctl.addr][8*l +: 8] <= ctl.data[8*l +: 8];
        end
      end
    end
  end

endmodule

// ----- rtl/core/sha1_round.sv -----
// ----------------------------------------------------------------------------
// sha1_round
// Shared round unit: one SHA-1 round per cycle for 80 rounds, then the
// chaining word update.
// ----------------------------------------------------------------------------
module sha1_round (
  input  logic                clk,
  input  logic                rst_n,
  input  sha1_pkg::rnd_ctl_t  ctl,
  input  logic [31:0]         w_in,
  output sha1_pkg::rnd_sts_t  sts,
  output logic [4:0][31:0]    chain
);
  import sha1_pkg::*;

  rnd_state_t       state_r, state_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic [4:0][31:0] regs_r;
  logic [4:0][31:0] chain_r;
  logic [1:0]       sel;
  logic [31:0]      temp;

  always_comb begin
    priority if (cnt_r < ROUND_SEL1) begin
      sel = 2'd0;
    end else if (cnt_r < ROUND_SEL2) begin
      sel = 2'd1;
    end else if (cnt_r < ROUND_SEL3) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
    temp = {regs_r[0][26:0], regs_r[0][31:27]}
         + round_f(sel, regs_r[1], regs_r[2], regs_r[3])
         + regs_r[4] + K_WORDS[sel] + w_in;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      R_IDLE: begin
        if (ctl.start) begin
          state_nxt = R_ROUND;
          cnt_nxt   = '0;
        end
      end
      R_ROUND: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == LAST_ROUND) begin
          state_nxt = R_ADD;
          cnt_nxt   = '0;
        end
      end
      R_ADD: state_nxt = R_IDLE;
      default: state_nxt = R_IDLE;
    endcase
    sts.busy = (state_r == R_ROUND);
    sts.done = (state_r == R_ADD);
    chain    = chain_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= IV_WORDS;
    end else if (ctl.reinit) begin
      chain_r <= IV_WORDS;
    end else if (state_r == R_ADD) begin
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= chain_r[i] + regs_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == R_IDLE && ctl.start) begin
      regs_r <= chain_r;
    end else if (state_r == R_ROUND) begin
      regs_r[4] <= regs_r[3];
      regs_r[3] <= regs_r[2];
      regs_r[2] <= {regs_r[1][1:0], regs_r[1][31:2]};
      regs_r[1] <= regs_r[0];
      regs_r[0] <= temp;
    end
  end

endmodule
